[hw/rtl/scalar_kalman_smoother_top_defines.svh]
// assertion macros for the scalar kalman smoother
`ifndef SCALAR_KALMAN_SMOOTHER_TOP_DEFINES_SVH
`define SCALAR_KALMAN_SMOOTHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle
`define SKF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skf assertion failed");
// condition holds in the following cycle
`define SKF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skf assertion failed");
`else
`define SKF_ASSERT_SAME(label, ante, cons)
`define SKF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/skf_pkg.sv]
package skf_pkg;

    // channel storage
    localparam int CHANNELS = 4;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W     = 2;
    localparam logic [7:0] CHANNELS_W8 = 8'(CHANNELS);

    // q16.16 data values; gains are unsigned q1.16
    localparam int DATA_W = 32;
    localparam int GAIN_W = 17;
    localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

    // gain divider: one quotient bit per step
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // shared multiplier
    localparam int MUL_A_W = DATA_W + 1;
    localparam int MUL_B_W = GAIN_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd1;
    localparam logic [DATA_W-1:0] MEAS_NOISE_RESET    = 32'd2621440;
    localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET = 32'd655360;

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [DATA_W-1:0] sample;
    } skf_in_t;

    typedef struct packed {
        logic [CH_W-1:0]          out_channel;
        logic signed [DATA_W-1:0] estimate;
    } skf_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_COV,
        ST_FIN
    } skf_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } skf_div_stat_t;

    // channel number folded onto the stored channels
    function automatic logic [CH_IDX_W-1:0] chan_index(input logic [CH_W-1:0] ch);
        logic [7:0] v;
        v = {6'b0, ch};
        for (int i = 0; i < 4; i++)
        begin
            if (v >= CHANNELS_W8)
            begin
                v = v - CHANNELS_W8;
            end
        end
        return v[CH_IDX_W-1:0];
    endfunction

endpackage

[hw/rtl/skf_gain_div.sv]
module skf_gain_div
    import skf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DATA_W-1:0]   cov,
    input  logic [DATA_W-1:0]   noise,
    output skf_div_stat_t       stat,
    output logic [GAIN_W-1:0]   gain
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DATA_W+1:0]     rem_reg;
    logic [DATA_W+1:0]     rem_next;
    logic [DATA_W+1:0]     rem_sub;
    logic [DATA_W:0]       den_reg;
    logic [DATA_W:0]       den_sum;
    logic [GAIN_W-1:0]     quot_reg;
    logic [GAIN_W-1:0]     quot_next;
    logic                  zero_reg;
    logic                  ge;

    // one restoring step: compare, subtract, shift
    always_comb
    begin
        den_sum   = {1'b0, cov} + {1'b0, noise};
        ge        = rem_reg >= {1'b0, den_reg};
        rem_sub   = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next  = {rem_sub[DATA_W:0], 1'b0};
        quot_next = {quot_reg[GAIN_W-2:0], ge};
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient; the first step yields the integer bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {2'b0, cov};
            den_reg  <= den_sum;
            quot_reg <= '0;
            zero_reg <= (den_sum == '0);
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign gain      = zero_reg ? '0 : quot_reg;

endmodule

[hw/rtl/scalar_kalman_smoother_top.sv]
// scalar kalman smoother: one estimate and one error covariance per channel
//
// meas channel (valid/ready): a beat carries a channel number and a signed
// q16.16 sample. est channel (valid/ready): a beat carries the channel number
// and that channel's updated estimate, one beat per measurement beat.
// cfg port: write enable, index and data; index 0 is the measurement noise r,
// index 1 the process noise q; other indexes are ignored. write only while idle.
//
// a measurement passes from its accept to its result beat through a load step
// to read the channel state, the bit-serial gain divider (17 quotient bits),
// the estimate and covariance products on the shared multiplier and a finish
// step. a new beat is taken the cycle after the result is registered, so the
// block takes no new measurement until the last one is through its finish step.
// a finished result waits in the output register; the next measurement is
// accepted and worked on meanwhile, and the block stalls only at its finish
// step until the earlier result beat is taken.
// reset clears all estimates and covariances to zero and restores r = 40.0
// and q = 10.0.
`include "scalar_kalman_smoother_top_defines.svh"

module scalar_kalman_smoother_top
    import skf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  meas_valid,
    output logic                  meas_ready,
    input  skf_in_t               meas,
    output logic                  est_valid,
    input  logic                  est_ready,
    output skf_out_t              est,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data
);

    skf_state_t               state_reg;
    skf_state_t               state_next;

    logic [DATA_W-1:0]        meas_noise_reg;
    logic [DATA_W-1:0]        process_noise_reg;

    logic [DATA_W-1:0]        est_store_reg [CHANNELS];
    logic [DATA_W-1:0]        cov_store_reg [CHANNELS];

    logic [CH_W-1:0]          ch_reg;
    logic [CH_IDX_W-1:0]      idx_reg;
    logic [DATA_W-1:0]        sample_reg;
    logic [DATA_W-1:0]        est_cur_reg;
    logic [DATA_W-1:0]        p_cur_reg;
    logic                     diff_neg_reg;
    logic [DATA_W:0]          diff_mag_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [DATA_W-1:0]        est_new_reg;

    logic                     out_valid_reg;
    skf_out_t                 out_data_reg;

    logic                     div_start;
    skf_div_stat_t            div_stat;
    logic [GAIN_W-1:0]        div_gain;

    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [PROD_W-1:0]        mul_prod;

    logic [DATA_W:0]          diff;
    logic [DATA_W+1:0]        est_sum;
    logic [DATA_W:0]          cov_sum;
    logic [DATA_W-1:0]        cov_new;
    logic                     out_free;
    logic                     fin_fire;

    // gain unit
    skf_gain_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .cov   (cov_store_reg[idx_reg]),
        .noise (meas_noise_reg),
        .stat  (div_stat),
        .gain  (div_gain)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (meas_valid) state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_DIV;
            ST_DIV:     if (div_stat.done) state_next = ST_MUL_EST;
            ST_MUL_EST: state_next = ST_MUL_COV;
            ST_MUL_COV: state_next = ST_FIN;
            ST_FIN:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and multiplier operand select
    always_comb
    begin
        meas_ready = 1'b0;
        div_start  = 1'b0;
        mul_a      = {1'b0, p_cur_reg};
        mul_b      = ONE_Q16 - gain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                meas_ready = 1'b1;
            end
            ST_LOAD:
            begin
                div_start = 1'b1;
            end
            ST_MUL_EST:
            begin
                mul_a = diff_mag_reg;
                mul_b = gain_reg;
            end
            default:
            begin
                meas_ready = 1'b0;
            end
        endcase
    end

    // shared datapath arithmetic
    always_comb
    begin
        mul_prod = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
        diff     = {sample_reg[DATA_W-1], sample_reg}
                 - {est_store_reg[idx_reg][DATA_W-1], est_store_reg[idx_reg]};
        // correction rounds toward zero: scale the magnitude, then apply the sign
        est_sum  = diff_neg_reg
                 ? ({{2{est_cur_reg[DATA_W-1]}}, est_cur_reg} - prod_reg[PROD_W-1:16])
                 : ({{2{est_cur_reg[DATA_W-1]}}, est_cur_reg} + prod_reg[PROD_W-1:16]);
        cov_sum  = {1'b0, prod_reg[DATA_W+15:16]} + {1'b0, process_noise_reg};
        cov_new  = cov_sum[DATA_W] ? {DATA_W{1'b1}} : cov_sum[DATA_W-1:0];
        out_free = !out_valid_reg || est_ready;
        fin_fire = (state_reg == ST_FIN) && out_free;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_noise_reg    <= MEAS_NOISE_RESET;
            process_noise_reg <= PROCESS_NOISE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MEAS_NOISE)
            begin
                meas_noise_reg <= cfg_data;
            end
            else if (cfg_index == REG_PROCESS_NOISE)
            begin
                process_noise_reg <= cfg_data;
            end
        end
    end

    // per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                est_store_reg[i] <= '0;
                cov_store_reg[i] <= '0;
            end
        end
        else if (fin_fire)
        begin
            est_store_reg[idx_reg] <= est_new_reg;
            cov_store_reg[idx_reg] <= cov_new;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (meas_valid)
                begin
                    ch_reg     <= meas.channel;
                    idx_reg    <= chan_index(meas.channel);
                    sample_reg <= meas.sample;
                end
            end
            ST_LOAD:
            begin
                est_cur_reg  <= est_store_reg[idx_reg];
                p_cur_reg    <= cov_store_reg[idx_reg];
                diff_neg_reg <= diff[DATA_W];
                diff_mag_reg <= diff[DATA_W] ? (~diff + 1'b1) : diff;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    gain_reg <= div_gain;
                end
            end
            ST_MUL_EST:
            begin
                prod_reg <= mul_prod;
            end
            ST_MUL_COV:
            begin
                est_new_reg <= est_sum[DATA_W-1:0];
                prod_reg    <= mul_prod;
            end
            default:
            begin
                est_new_reg <= est_new_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (est_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            out_data_reg.out_channel <= ch_reg;
            out_data_reg.estimate    <= est_new_reg;
        end
    end

    assign est_valid = out_valid_reg;
    assign est       = out_data_reg;

    // checks
    `SKF_ASSERT_SAME(a_div_done_in_div, div_stat.done, state_reg == ST_DIV)
    `SKF_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy)
    `SKF_ASSERT_SAME(a_gain_bound, state_reg == ST_MUL_EST, gain_reg <= ONE_Q16)
    `SKF_ASSERT_NEXT(a_busy_after_accept, meas_valid && meas_ready, !meas_ready)

endmodule
